FILE: rtl/periodic_waveform_sample_generator_unit_assert.svh
// Assertion macros used by the waveform generator top-level RTL.
`ifndef PERIODIC_WAVEFORM_SAMPLE_GENERATOR_UNIT_ASSERT_SVH
`define PERIODIC_WAVEFORM_SAMPLE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PWSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pwsg_pkg.sv
`default_nettype none
package pwsg_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PERIOD_W        = 32;
  localparam int LEVEL_W         = 14;
  localparam int FULL_SCALE      = 10000;

  // register indexes
  localparam logic [1:0] REG_WAVE_KIND    = 2'd0;
  localparam logic [1:0] REG_PERIOD_TICKS = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE    = 2'd2;
  localparam logic [1:0] REG_LEVEL_OFFSET = 2'd3;

  // item functions
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_BAD    = 2'd3;

  // wave kinds
  localparam logic [2:0] KIND_SINE   = 3'd0;
  localparam logic [2:0] KIND_SAW    = 3'd1;
  localparam logic [2:0] KIND_TRI    = 3'd2;
  localparam logic [2:0] KIND_SQUARE = 3'd3;
  localparam logic [2:0] KIND_CUSTOM = 3'd4;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_AT   = 3'd1;
  localparam logic [2:0] MUL_APT  = 3'd2;
  localparam logic [2:0] MUL_SINE = 3'd3;
  localparam logic [2:0] MUL_TN   = 3'd4;
  localparam logic [2:0] MUL_DREM = 3'd5;
  localparam logic [2:0] MUL_VA   = 3'd6;

  // divider operand selects
  localparam logic [2:0] DIV_SINE = 3'd0;
  localparam logic [2:0] DIV_P    = 3'd1;
  localparam logic [2:0] DIV_H    = 3'd2;
  localparam logic [2:0] DIV_PH   = 3'd3;

  // table read address selects
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_LAST = 2'd1;
  localparam logic [1:0] RD_I    = 2'd2;
  localparam logic [1:0] RD_I1   = 2'd3;

  // level register updates
  localparam logic [2:0] LVL_KEEP = 3'd0;
  localparam logic [2:0] LVL_SQ   = 3'd1;
  localparam logic [2:0] LVL_SINE = 3'd2;
  localparam logic [2:0] LVL_Q    = 3'd3;
  localparam logic [2:0] LVL_NORM = 3'd4;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       append;
    logic       clear;
    logic       finish;
    logic [2:0] mul_op;
    logic       div_start;
    logic [2:0] div_op;
    logic       mem_rd;
    logic [1:0] rd_op;
    logic       sine_ld;
    logic       idx_load;
    logic       p0_load;
    logic       p1_load;
    logic       v_load;
    logic       v_interp;
    logic [2:0] lvl_op;
  } pwsg_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] kind;
    logic       t_lt_h;
    logic       cnt_zero;
    logic       cnt_one;
    logic       idx_last;
    logic       div_done;
  } pwsg_stat_t;

  // quarter-wave sine, Q15, sampled at x = i*256 (Q16), i = 0..256
  typedef logic [15:0] sine_tab_t [0:256];

  function automatic sine_tab_t sine_build();
    sine_tab_t tab;
    longint unsigned x, x2, a, b, c, s;
    for (int i = 0; i <= 256; i++) begin
      x  = 64'(i) << 8;
      x2 = (x * x) >> 16;
      a  = 64'd85569305 - ((x2 * 64'd5026995) >> 16);
      b  = 64'd693598668 - ((x2 * a) >> 16);
      c  = 64'd1686629713 - ((x2 * b) >> 16);
      s  = (x * c) >> 31;
      tab[i] = (s > 64'd32768) ? 16'd32768 : s[15:0];
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pwsg_div.sv
`default_nettype none
module pwsg_div #(
  parameter int DW = 46,
  parameter int VW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);
  localparam int CNW = $clog2(DW + 1);

  logic [CNW-1:0] cnt;
  logic [VW-1:0]  dsr;
  logic [VW:0]    shifted;
  logic           ge;

  assign shifted = {remainder, quotient[DW-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (cnt != '0) begin
      quotient  <= {quotient[DW-2:0], ge};
      remainder <= ge ? VW'(shifted - {1'b0, dsr}) : shifted[VW-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pwsg_ctrl.sv
`default_nettype none
module pwsg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire pwsg_pkg::pwsg_stat_t stat,
  output pwsg_pkg::pwsg_cmd_t       cmd,
  output logic                      busy
);
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_PREP     = 5'd2;
  localparam logic [4:0] S_KIND     = 5'd3;
  localparam logic [4:0] S_SIN_WAIT = 5'd4;
  localparam logic [4:0] S_SIN_MUL  = 5'd5;
  localparam logic [4:0] S_SIN_RND  = 5'd6;
  localparam logic [4:0] S_SAW_DIV  = 5'd7;
  localparam logic [4:0] S_TRI_DIV  = 5'd8;
  localparam logic [4:0] S_Q_WAIT   = 5'd9;
  localparam logic [4:0] S_C_V0     = 5'd10;
  localparam logic [4:0] S_C_SCALE  = 5'd11;
  localparam logic [4:0] S_C_NORM   = 5'd12;
  localparam logic [4:0] S_C_DIV1   = 5'd13;
  localparam logic [4:0] S_C_IDX    = 5'd14;
  localparam logic [4:0] S_C_RD0    = 5'd15;
  localparam logic [4:0] S_C_RD1    = 5'd16;
  localparam logic [4:0] S_C_P1     = 5'd17;
  localparam logic [4:0] S_C_DIFF   = 5'd18;
  localparam logic [4:0] S_C_DIV2   = 5'd19;
  localparam logic [4:0] S_C_INT    = 5'd20;
  localparam logic [4:0] S_FIN      = 5'd21;

  logic [4:0] state, state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.func)
          pwsg_pkg::FUNC_SAMPLE: state_next = S_PREP;
          pwsg_pkg::FUNC_APPEND: begin
            cmd.append = 1'b1;
            state_next = S_FIN;
          end
          pwsg_pkg::FUNC_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_FIN;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_KIND;
      end
      S_KIND: begin
        unique case (stat.kind)
          pwsg_pkg::KIND_SINE: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = pwsg_pkg::DIV_SINE;
            state_next    = S_SIN_WAIT;
          end
          pwsg_pkg::KIND_SAW: begin
            cmd.mul_op = pwsg_pkg::MUL_AT;
            state_next = S_SAW_DIV;
          end
          pwsg_pkg::KIND_TRI: begin
            cmd.mul_op = stat.t_lt_h ? pwsg_pkg::MUL_AT : pwsg_pkg::MUL_APT;
            state_next = S_TRI_DIV;
          end
          pwsg_pkg::KIND_SQUARE: begin
            cmd.lvl_op = pwsg_pkg::LVL_SQ;
            state_next = S_FIN;
          end
          pwsg_pkg::KIND_CUSTOM: begin
            priority if (stat.cnt_zero) begin
              state_next = S_FIN;
            end else if (stat.cnt_one) begin
              cmd.mem_rd = 1'b1;
              cmd.rd_op  = pwsg_pkg::RD_ZERO;
              state_next = S_C_V0;
            end else begin
              cmd.mul_op = pwsg_pkg::MUL_TN;
              state_next = S_C_DIV1;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SIN_WAIT: begin
        if (stat.div_done) begin
          cmd.sine_ld = 1'b1;
          state_next  = S_SIN_MUL;
        end
      end
      S_SIN_MUL: begin
        cmd.mul_op = pwsg_pkg::MUL_SINE;
        state_next = S_SIN_RND;
      end
      S_SIN_RND: begin
        cmd.lvl_op = pwsg_pkg::LVL_SINE;
        state_next = S_FIN;
      end
      S_SAW_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pwsg_pkg::DIV_P;
        state_next    = S_Q_WAIT;
      end
      S_TRI_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = stat.t_lt_h ? pwsg_pkg::DIV_H : pwsg_pkg::DIV_PH;
        state_next    = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (stat.div_done) begin
          cmd.lvl_op = pwsg_pkg::LVL_Q;
          state_next = S_FIN;
        end
      end
      S_C_V0: begin
        cmd.v_load = 1'b1;
        state_next = S_C_SCALE;
      end
      S_C_SCALE: begin
        cmd.mul_op = pwsg_pkg::MUL_VA;
        state_next = S_C_NORM;
      end
      S_C_NORM: begin
        cmd.lvl_op = pwsg_pkg::LVL_NORM;
        state_next = S_FIN;
      end
      S_C_DIV1: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pwsg_pkg::DIV_P;
        state_next    = S_C_IDX;
      end
      S_C_IDX: begin
        if (stat.div_done) begin
          cmd.idx_load = 1'b1;
          state_next   = S_C_RD0;
        end
      end
      S_C_RD0: begin
        cmd.mem_rd = 1'b1;
        if (stat.idx_last) begin
          cmd.rd_op  = pwsg_pkg::RD_LAST;
          state_next = S_C_V0;
        end else begin
          cmd.rd_op  = pwsg_pkg::RD_I;
          state_next = S_C_RD1;
        end
      end
      S_C_RD1: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_op   = pwsg_pkg::RD_I1;
        cmd.p0_load = 1'b1;
        state_next  = S_C_P1;
      end
      S_C_P1: begin
        cmd.p1_load = 1'b1;
        state_next  = S_C_DIFF;
      end
      S_C_DIFF: begin
        cmd.mul_op = pwsg_pkg::MUL_DREM;
        state_next = S_C_DIV2;
      end
      S_C_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pwsg_pkg::DIV_P;
        state_next    = S_C_INT;
      end
      S_C_INT: begin
        if (stat.div_done) begin
          cmd.v_interp = 1'b1;
          state_next   = S_C_SCALE;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/pwsg_dp.sv
`default_nettype none
module pwsg_dp #(
  parameter int TABLE_DEPTH = pwsg_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic [1:0]           func,
  input  wire logic [31:0]          time_in_period,
  input  wire logic [13:0]          point_value,
  input  wire pwsg_pkg::pwsg_cmd_t  cmd,
  output pwsg_pkg::pwsg_stat_t      stat,
  output logic                      done,
  output logic [13:0]               sample_level,
  output logic                      accepted
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MA = (CW > 14) ? CW : 14;
  localparam int PW = MA + pwsg_pkg::PERIOD_W;
  localparam pwsg_pkg::sine_tab_t SINE_TAB = pwsg_pkg::sine_build();
  // ceil(2^35 / 625): x/10000 = ((x >> 4) * RECIP_625) >> 35, exact for x below 2^29
  localparam logic [25:0] RECIP_625 = 26'd54975582;

  // configuration
  logic [2:0]  wave_kind;
  logic [31:0] period_ticks;
  logic [13:0] amplitude;
  logic [14:0] level_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_kind    <= pwsg_pkg::KIND_SINE;
      period_ticks <= 32'd1000;
      amplitude    <= 14'd10000;
      level_offset <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pwsg_pkg::REG_WAVE_KIND:    wave_kind    <= cfg_data[2:0];
        pwsg_pkg::REG_PERIOD_TICKS: period_ticks <= cfg_data;
        pwsg_pkg::REG_AMPLITUDE:    amplitude    <= cfg_data[13:0];
        pwsg_pkg::REG_LEVEL_OFFSET: level_offset <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [1:0]  func_r;
  logic [31:0] t_raw, teff, per, half, per_h;
  logic [13:0] pv;
  logic        ok;

  // point table
  logic [13:0]   mem [TABLE_DEPTH];
  logic [13:0]   rdata;
  logic [CW-1:0] count;
  logic [CW-1:0] nm1;
  logic          cnt_full;
  logic [AW-1:0] idx, rd_addr;
  logic          idx_last;
  logic [31:0]   rem_r;

  assign nm1      = count - 1'b1;
  assign cnt_full = count == CW'(TABLE_DEPTH);

  always_comb begin
    unique case (cmd.rd_op)
      pwsg_pkg::RD_ZERO: rd_addr = '0;
      pwsg_pkg::RD_LAST: rd_addr = nm1[AW-1:0];
      pwsg_pkg::RD_I:    rd_addr = idx;
      default:           rd_addr = idx + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !cnt_full) begin
      mem[count[AW-1:0]] <= pv;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && !cnt_full) begin
      count <= count + 1'b1;
    end
  end

  // shared multiplier
  logic [MA-1:0] ma;
  logic [31:0]   mb;
  logic [PW-1:0] prod;
  logic [16:0]   sv;
  logic [13:0]   diff, p0, v;
  logic          p1_ge;

  always_comb begin
    ma = MA'(amplitude);
    mb = teff;
    unique case (cmd.mul_op)
      pwsg_pkg::MUL_APT:  mb = per - teff;
      pwsg_pkg::MUL_SINE: mb = 32'(sv);
      pwsg_pkg::MUL_TN:   ma = MA'(nm1);
      pwsg_pkg::MUL_DREM: begin
        ma = MA'(diff);
        mb = rem_r;
      end
      pwsg_pkg::MUL_VA: begin
        ma = MA'(v);
        mb = 32'(amplitude);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != pwsg_pkg::MUL_NONE) begin
      prod <= ma * mb;
    end
  end

  // scale by 1/10000: v*a stays below 2^28
  logic [50:0] nprod;
  assign nprod = 51'(prod[28:4]) * 51'(RECIP_625);

  // shared divider
  logic [PW-1:0] dvd, quo;
  logic [31:0]   dvs, rem;
  logic          div_done;

  always_comb begin
    dvd = prod;
    unique case (cmd.div_op)
      pwsg_pkg::DIV_SINE: begin
        dvd = PW'({teff, 10'b0});
        dvs = per;
      end
      pwsg_pkg::DIV_H:  dvs = half;
      pwsg_pkg::DIV_PH: dvs = per_h;
      default:          dvs = per;
    endcase
  end

  pwsg_div #(.DW(PW), .VW(pwsg_pkg::PERIOD_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // sine lookup from phase index k = quo[9:0]
  logic [8:0]  sidx;
  logic [15:0] sval;
  assign sidx = quo[8] ? (9'd256 - {1'b0, quo[7:0]}) : {1'b0, quo[7:0]};
  assign sval = SINE_TAB[sidx];

  logic [PW-1:0] prnd;
  assign prnd = prod + PW'(32768);

  logic [15:0] lvl;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      t_raw  <= time_in_period;
      pv     <= point_value;
      ok     <= func != pwsg_pkg::FUNC_BAD;
      lvl    <= '0;
    end
    if (cmd.append) begin
      ok <= !cnt_full;
    end
    if (cmd.prep) begin
      if (period_ticks < 32'd2) begin
        per   <= 32'd2;
        half  <= 32'd1;
        per_h <= 32'd1;
        teff  <= (t_raw >= 32'd2) ? 32'd1 : t_raw;
      end else begin
        per   <= period_ticks;
        half  <= period_ticks >> 1;
        per_h <= period_ticks - (period_ticks >> 1);
        teff  <= (t_raw >= period_ticks) ? period_ticks - 1'b1 : t_raw;
      end
    end
    if (cmd.sine_ld) begin
      sv <= quo[9] ? (17'd32768 - {1'b0, sval}) : (17'd32768 + {1'b0, sval});
    end
    if (cmd.idx_load) begin
      idx      <= quo[AW-1:0];
      rem_r    <= rem;
      idx_last <= quo >= PW'(nm1);
    end
    if (cmd.p0_load) begin
      p0 <= rdata;
    end
    if (cmd.p1_load) begin
      p1_ge <= rdata >= p0;
      diff  <= (rdata >= p0) ? rdata - p0 : p0 - rdata;
    end
    if (cmd.v_load) begin
      v <= rdata;
    end
    if (cmd.v_interp) begin
      v <= p1_ge ? p0 + quo[13:0] : p0 - quo[13:0];
    end
    unique case (cmd.lvl_op)
      pwsg_pkg::LVL_SQ:   lvl <= (teff < half) ? 16'(amplitude) : 16'd0;
      pwsg_pkg::LVL_SINE: lvl <= prnd[31:16];
      pwsg_pkg::LVL_Q:    lvl <= quo[15:0];
      pwsg_pkg::LVL_NORM: lvl <= nprod[50:35];
      default: ;
    endcase
  end

  // offset and clamp
  logic signed [18:0] sum;
  assign sum = signed'({3'b000, lvl}) + signed'({{4{level_offset[14]}}, level_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      accepted <= ok;
      priority if (func_r != pwsg_pkg::FUNC_SAMPLE) begin
        sample_level <= '0;
      end else if (sum < 0) begin
        sample_level <= '0;
      end else if (sum > 19'(pwsg_pkg::FULL_SCALE)) begin
        sample_level <= 14'(pwsg_pkg::FULL_SCALE);
      end else begin
        sample_level <= sum[13:0];
      end
    end
  end

  assign stat.func     = func_r;
  assign stat.kind     = wave_kind;
  assign stat.t_lt_h   = teff < half;
  assign stat.cnt_zero = count == '0;
  assign stat.cnt_one  = count == CW'(1);
  assign stat.idx_last = idx_last;
  assign stat.div_done = div_done;
endmodule
`default_nettype wire

FILE: rtl/periodic_waveform_sample_generator_unit.sv
// Periodic waveform sample generator.
// Command channel: pulse start while busy is low with func, time_in_period
// and point_value; that cycle is the transfer. func 0 returns the level at
// that time within the period (sine, sawtooth, triangle, square or custom
// point table, then offset and clamp to 0..10000); func 1 appends a point
// to the custom table (accepted 0 when full); func 2 clears the table.
// Result: done is high for exactly one cycle with sample_level and accepted.
// The receiver cannot stall; the result is simply presented for one cycle.
// Divider: D = 32 + max(14, count width) quotient bits (46 at default
// depth), one quotient bit per cycle. Append, clear and invalid func use
// neither multiplier nor divider; square, undefined kind, empty custom
// table and custom with one point skip the divider; sine, saw and tri
// pass through it once; custom with two or more points passes twice.
// The divider is shared by all these passes; one item is in flight at a
// time and the next transfer may be taken in the cycle done is high.
// Reset: config returns to sine, period 1000, amplitude 10000, offset 0,
// and the point table is emptied. Config writes are taken any cycle, but
// only while idle is their effect defined.
`default_nettype none
module periodic_waveform_sample_generator_unit #(
  parameter int TABLE_DEPTH = pwsg_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] time_in_period,
  input  wire logic [13:0] point_value,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             done,
  output logic [13:0]      sample_level,
  output logic             accepted
);
`include "periodic_waveform_sample_generator_unit_assert.svh"

  pwsg_pkg::pwsg_cmd_t  cmd;
  pwsg_pkg::pwsg_stat_t stat;

  // sequencer: decodes func and kind, steps the datapath through
  // multiply / divide / table-read phases
  pwsg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: config registers, point table, shared multiplier,
  // serial divider, sine quarter table, offset and clamp
  pwsg_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .time_in_period (time_in_period),
    .point_value    (point_value),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .sample_level   (sample_level),
    .accepted       (accepted)
  );

  `PWSG_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer did not start work")
  `PWSG_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
  `PWSG_ASSERT_NOW(a_level_range, done, sample_level <= 14'd10000, "level above full scale")
  `PWSG_ASSERT_NEXT(a_done_single, done, !done, "result strobe repeated")

endmodule
`default_nettype wire
